// ----- rtl/sqt_pkg.sv -----
package sqt_pkg;

	localparam int POS_W       = 24;
	localparam int DIM_W       = 20;
	localparam int ANG_W       = 16;
	localparam int SCL_W       = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 24;
	localparam int ATAN_N      = 24;
	localparam int CORDIC_DEF  = 16;
	localparam int CW          = 34;
	localparam int OFF_W       = 43;
	localparam int TRIG_W      = 16;
	localparam int PROD_W      = 60;

	localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [TRIG_W-1:0] UNIT = 16'sd16384;
	localparam logic signed [POS_W-1:0] POS_MAX = 24'sh7FFFFF;
	localparam logic signed [POS_W-1:0] POS_MIN = -24'sh800000;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HOT_X  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HOT_Y  = 2'd3;

	function automatic logic signed [CW-1:0] atan_val(input int i);
		logic signed [CW-1:0] r;
		begin
			case (i)
				0: r = 34'sh20000000;
				1: r = 34'sh12E4051E;
				2: r = 34'sh09FB385B;
				3: r = 34'sh051111D4;
				4: r = 34'sh028B0D43;
				5: r = 34'sh0145D7E1;
				6: r = 34'sh00A2F61E;
				7: r = 34'sh00517C55;
				8: r = 34'sh0028BE53;
				9: r = 34'sh00145F2F;
				10: r = 34'sh000A2F98;
				11: r = 34'sh000517CC;
				12: r = 34'sh00028BE6;
				13: r = 34'sh000145F3;
				14: r = 34'sh0000A2FA;
				15: r = 34'sh0000517D;
				16: r = 34'sh000028BE;
				17: r = 34'sh0000145F;
				18: r = 34'sh00000A30;
				19: r = 34'sh00000518;
				20: r = 34'sh0000028C;
				21: r = 34'sh00000146;
				22: r = 34'sh000000A3;
				23: r = 34'sh00000051;
				default: r = '0;
			endcase
			return r;
		end
	endfunction

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
	} cordic_t;

	typedef struct packed {
		logic                     zero_r;
		logic [1:0]               quad;
		logic signed [POS_W-1:0]  pos_x;
		logic signed [POS_W-1:0]  pos_y;
		logic signed [OFF_W-1:0]  offx0;
		logic signed [OFF_W-1:0]  offx1;
		logic signed [OFF_W-1:0]  offy0;
		logic signed [OFF_W-1:0]  offy1;
	} side_t;

endpackage

// ----- rtl/sqt_cordic_cell.sv -----
module sqt_cordic_cell import sqt_pkg::*; #(
	parameter int SHIFT = 0
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  logic    vin,
	input  cordic_t din,
	input  side_t   sin,
	output logic    vout,
	output cordic_t dout,
	output side_t   sout
);
	cordic_t nxt;
	logic signed [CW-1:0] dx;
	logic signed [CW-1:0] dy;

	always_comb begin
		dx = din.x >>> SHIFT;
		dy = din.y >>> SHIFT;
		if (!din.z[CW-1]) begin
			nxt.x = din.x - dy;
			nxt.y = din.y + dx;
			nxt.z = din.z - atan_val(SHIFT);
		end else begin
			nxt.x = din.x + dy;
			nxt.y = din.y - dx;
			nxt.z = din.z + atan_val(SHIFT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vout <= 1'b0;
		end else if (en) begin
			vout <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout <= nxt;
			sout <= sin;
		end
	end
endmodule

// ----- rtl/sqt_corner_unit.sv -----
module sqt_corner_unit import sqt_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     vin,
	input  side_t                    side,
	input  logic signed [TRIG_W-1:0] c,
	input  logic signed [TRIG_W-1:0] s,
	output logic                     busy,
	input  logic                     stall,
	output logic                     valid,
	output logic signed [POS_W-1:0]  corner_x,
	output logic signed [POS_W-1:0]  corner_y,
	output logic [1:0]               corner_index,
	output logic                     last_corner,
	output logic signed [POS_W-1:0]  box_min_x,
	output logic signed [POS_W-1:0]  box_min_y,
	output logic signed [POS_W-1:0]  box_max_x,
	output logic signed [POS_W-1:0]  box_max_y
);
	side_t                    sd_q;
	logic signed [TRIG_W-1:0] c_q, s_q;
	logic [1:0]               k_q;
	logic                     act_q;

	logic                     v_s1;
	logic [1:0]               k_s1;
	logic signed [POS_W-1:0]  px_s1, py_s1;
	logic signed [PROD_W-1:0] p0_s1, p1_s1, p2_s1, p3_s1;

	logic                     v_s2;
	logic [1:0]               k_s2;
	logic signed [POS_W-1:0]  rx_s2, ry_s2;

	logic signed [OFF_W-1:0]  tx, ty;
	logic signed [PROD_W-1:0] sx, sy;
	logic signed [PROD_W-1:0] ax, ay;
	logic signed [PROD_W-1:0] fx, fy;
	logic                     adv;

	assign adv  = !(valid && stall);
	assign busy = !adv || (act_q && k_q != 2'd3);

	always_comb begin
		tx = (k_q == 2'd1 || k_q == 2'd2) ? sd_q.offx1 : sd_q.offx0;
		ty = (k_q[1]) ? sd_q.offy1 : sd_q.offy0;
		sx = p0_s1 - p1_s1 + (PROD_W'(1) <<< 21);
		sy = p2_s1 + p3_s1 + (PROD_W'(1) <<< 21);
		ax = (sx >>> 22) + PROD_W'(px_s1);
		ay = (sy >>> 22) + PROD_W'(py_s1);
		fx = (ax > PROD_W'(POS_MAX)) ? PROD_W'(POS_MAX) :
			(ax < PROD_W'(POS_MIN)) ? PROD_W'(POS_MIN) : ax;
		fy = (ay > PROD_W'(POS_MAX)) ? PROD_W'(POS_MAX) :
			(ay < PROD_W'(POS_MIN)) ? PROD_W'(POS_MIN) : ay;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			k_q   <= '0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			valid <= 1'b0;
		end else if (adv) begin
			if (vin && !busy) begin
				act_q <= 1'b1;
				k_q   <= '0;
			end else if (act_q) begin
				k_q <= k_q + 2'd1;
				if (k_q == 2'd3) begin
					act_q <= 1'b0;
				end
			end
			v_s1  <= act_q;
			v_s2  <= v_s1;
			valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (vin && !busy) begin
				sd_q <= side;
				c_q  <= c;
				s_q  <= s;
			end
			k_s1  <= k_q;
			px_s1 <= sd_q.pos_x;
			py_s1 <= sd_q.pos_y;
			p0_s1 <= PROD_W'(tx) * PROD_W'(c_q);
			p1_s1 <= PROD_W'(ty) * PROD_W'(s_q);
			p2_s1 <= PROD_W'(tx) * PROD_W'(s_q);
			p3_s1 <= PROD_W'(ty) * PROD_W'(c_q);
			k_s2  <= k_s1;
			rx_s2 <= POS_W'(fx);
			ry_s2 <= POS_W'(fy);
			corner_x     <= rx_s2;
			corner_y     <= ry_s2;
			corner_index <= k_s2;
			last_corner  <= (k_s2 == 2'd3);
			if (k_s2 == 2'd0) begin
				box_min_x <= rx_s2;
				box_max_x <= rx_s2;
				box_min_y <= ry_s2;
				box_max_y <= ry_s2;
			end else begin
				box_min_x <= (rx_s2 < box_min_x) ? rx_s2 : box_min_x;
				box_max_x <= (rx_s2 > box_max_x) ? rx_s2 : box_max_x;
				box_min_y <= (ry_s2 < box_min_y) ? ry_s2 : box_min_y;
				box_max_y <= (ry_s2 > box_max_y) ? ry_s2 : box_max_y;
			end
		end
	end
endmodule

// ----- rtl/sprite_quad_transform_top.sv -----
// Sprite quad transform.
// Input channel (valid/stall): one sprite placement per transaction with
// pos_x, pos_y, angle, scale_h, scale_v.
// Output channel (valid/stall): four transactions per placement, corners
// 0..3 with a running bounding box that is complete on last_corner.
// Config channel (cfg_valid/cfg_ready): cfg_index selects width, height,
// hotspot x, hotspot y; write only while the block is idle.
// Path: an input register, the CORDIC row of CORDIC_STAGES cells
// (stage count limited to 24), then the corner unit's capture, product,
// sum and output registers. The corner unit emits one corner per cycle
// unless stalled; the row takes a new angle each cycle unless stalled.
// Reset clears all valid flags and the config registers to zero.
// A stalled output freezes the corner unit; the row then holds once its
// last cell carries a placement, and the input stall rises.
module sprite_quad_transform_top import sqt_pkg::*; #(
	parameter int CORDIC_STAGES = CORDIC_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic signed [POS_W-1:0] pos_x,
	input  logic signed [POS_W-1:0] pos_y,
	input  logic [ANG_W-1:0]        angle,
	input  logic [SCL_W-1:0]        scale_h,
	input  logic [SCL_W-1:0]        scale_v,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [POS_W-1:0] corner_x,
	output logic signed [POS_W-1:0] corner_y,
	output logic [1:0]              corner_index,
	output logic                    last_corner,
	output logic signed [POS_W-1:0] box_min_x,
	output logic signed [POS_W-1:0] box_min_y,
	output logic signed [POS_W-1:0] box_max_x,
	output logic signed [POS_W-1:0] box_max_y
);
	localparam int N = (CORDIC_STAGES > ATAN_N) ? ATAN_N : CORDIC_STAGES;

	logic [DIM_W-1:0]        width_q, height_q;
	logic signed [POS_W-1:0] hot_x_q, hot_y_q;

	logic       v_s1;
	cordic_t    c_s1;
	side_t      sd_s1;
	logic       cell_v [N+1];
	cordic_t    cell_d [N+1];
	side_t      cell_s [N+1];
	logic       v_t, busy, en, take;
	logic signed [TRIG_W-1:0] c_t, s_t, c0, s0, c0r, s0r;
	logic signed [CW-1:0]     xr, yr;
	side_t      sd_t;
	logic [SCL_W-1:0] sv;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= '0;
			height_q <= '0;
			hot_x_q  <= '0;
			hot_y_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data[DIM_W-1:0];
				REG_HEIGHT: height_q <= cfg_data[DIM_W-1:0];
				REG_HOT_X:  hot_x_q  <= cfg_data;
				REG_HOT_Y:  hot_y_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Row advances whenever its tail can move into the corner unit.
	assign en       = !(cell_v[N] && busy);
	assign in_stall = !en;
	assign take     = in_valid && !in_stall;
	assign sv       = (scale_v == '0) ? scale_h : scale_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1.x <= CORDIC_GAIN;
			c_s1.y <= '0;
			c_s1.z <= CW'({angle[13:0], 16'd0});
			sd_s1.zero_r <= (angle[13:0] == '0);
			sd_s1.quad   <= angle[15:14];
			sd_s1.pos_x  <= pos_x;
			sd_s1.pos_y  <= pos_y;
			sd_s1.offx0  <= OFF_W'(-(OFF_W'(hot_x_q))) * OFF_W'({1'b0, scale_h});
			sd_s1.offx1  <= (OFF_W'({1'b0, width_q}) - OFF_W'(hot_x_q))
				* OFF_W'({1'b0, scale_h});
			sd_s1.offy0  <= OFF_W'(-(OFF_W'(hot_y_q))) * OFF_W'({1'b0, sv});
			sd_s1.offy1  <= (OFF_W'({1'b0, height_q}) - OFF_W'(hot_y_q))
				* OFF_W'({1'b0, sv});
		end
	end

	assign cell_v[0] = v_s1;
	assign cell_d[0] = c_s1;
	assign cell_s[0] = sd_s1;

	for (genvar i = 0; i < N; i++) begin : g_row
		sqt_cordic_cell #(.SHIFT(i)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vin(cell_v[i]), .din(cell_d[i]), .sin(cell_s[i]),
			.vout(cell_v[i+1]), .dout(cell_d[i+1]), .sout(cell_s[i+1])
		);
	end

	always_comb begin
		xr  = (cell_d[N].x + (CW'(1) <<< 15)) >>> 16;
		yr  = (cell_d[N].y + (CW'(1) <<< 15)) >>> 16;
		c0r = (xr > CW'(UNIT)) ? UNIT : (xr < -CW'(UNIT)) ? -UNIT : TRIG_W'(xr);
		s0r = (yr > CW'(UNIT)) ? UNIT : (yr < -CW'(UNIT)) ? -UNIT : TRIG_W'(yr);
		c0  = cell_s[N].zero_r ? UNIT : c0r;
		s0  = cell_s[N].zero_r ? '0 : s0r;
		case (cell_s[N].quad)
			2'd0: begin c_t = c0;  s_t = s0;  end
			2'd1: begin c_t = -s0; s_t = c0;  end
			2'd2: begin c_t = -c0; s_t = -s0; end
			default: begin c_t = s0; s_t = -c0; end
		endcase
		sd_t = cell_s[N];
		v_t  = cell_v[N];
	end

	sqt_corner_unit u_corner (
		.clk(clk), .arst_n(arst_n), .vin(v_t), .side(sd_t), .c(c_t), .s(s_t),
		.busy(busy), .stall(out_stall), .valid(out_valid),
		.corner_x(corner_x), .corner_y(corner_y), .corner_index(corner_index),
		.last_corner(last_corner), .box_min_x(box_min_x), .box_min_y(box_min_y),
		.box_max_x(box_max_x), .box_max_y(box_max_y)
	);
endmodule

// ----- rtl/sqt_checker.sv -----
module sqt_checker import sqt_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic [1:0]              corner_index,
	input logic                    last_corner,
	input logic signed [POS_W-1:0] corner_x,
	input logic signed [POS_W-1:0] box_min_x,
	input logic signed [POS_W-1:0] box_max_x
);
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_corner == (corner_index == 2'd3)))
		else $error("last_corner mismatch");
	a_box: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (box_min_x <= corner_x && corner_x <= box_max_x))
		else $error("corner outside box");
	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && corner_index == 2'd0) |-> (box_min_x == corner_x))
		else $error("box not restarted");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(corner_x)))
		else $error("stalled output changed");
endmodule

bind sprite_quad_transform_top sqt_checker u_sqt_checker (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_stall(out_stall),
	.corner_index(corner_index), .last_corner(last_corner),
	.corner_x(corner_x), .box_min_x(box_min_x), .box_max_x(box_max_x)
);
